// ----- rtl/job_deadline_scheduler_defines.svh -----
// assertion macros for the job deadline scheduler
`ifndef JOB_DEADLINE_SCHEDULER_DEFINES_SVH
`define JOB_DEADLINE_SCHEDULER_DEFINES_SVH

// property holds at every clock edge outside reset
`define JDS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition never occurs outside reset
`define JDS_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/jds_pkg.sv -----
package jds_pkg;

	localparam int MaxJobs = 64;
	localparam int IdxW = $clog2(MaxJobs);
	localparam int CountW = $clog2(MaxJobs + 1);
	localparam int ProfitW = 16;
	localparam int DeadlineInW = 8;
	localparam int SumW = 22;
	localparam int EntryW = ProfitW + CountW;

	typedef enum logic [1:0] {
		SCH_IDLE,
		SCH_SCAN,
		SCH_SLOT,
		SCH_DONE
	} sch_state_t;

	typedef struct packed {
		logic              start;
		logic [CountW-1:0] n;
	} sched_ctl_t;

	typedef struct packed {
		logic              done;
		logic [CountW-1:0] count;
		logic [SumW-1:0]   sum;
	} sched_res_t;

endpackage

// ----- rtl/jds_ram.sv -----
module jds_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/jds_sched.sv -----
module jds_sched (
	input  logic                         clk,
	input  logic                         arst_n,
	input  jds_pkg::sched_ctl_t          ctl,
	input  logic                         hold,
	input  logic [jds_pkg::EntryW-1:0]   rd_data,
	output logic [jds_pkg::IdxW-1:0]     rd_addr,
	output jds_pkg::sched_res_t          res
);
	import jds_pkg::*;

	sch_state_t state_q, state_d;
	logic [CountW-1:0]  cnt_q;
	logic               vld_s1;
	logic [IdxW-1:0]    idx_s1;
	logic               have_q;
	logic [IdxW-1:0]    best_idx_q;
	logic [ProfitW-1:0] best_p_q;
	logic [CountW-1:0]  best_d_q;
	logic [CountW-1:0]  slot_q;
	logic [MaxJobs-1:0] picked_q;
	logic [MaxJobs-1:0] taken_q;
	logic [CountW-1:0]  count_q;
	logic [SumW-1:0]    sum_q;

	logic               rd_en;
	logic               scan_end;
	logic               slot_zero;
	logic               slot_free;
	logic [CountW-1:0]  slot_m1;
	logic [ProfitW-1:0] rd_p;
	logic [CountW-1:0]  rd_d;

	assign rd_p    = rd_data[EntryW-1 -: ProfitW];
	assign rd_d    = rd_data[CountW-1:0];
	assign slot_m1 = slot_q - 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SCH_IDLE: begin
				if (ctl.start) state_d = SCH_SCAN;
			end
			SCH_SCAN: begin
				if (scan_end) state_d = have_q ? SCH_SLOT : SCH_DONE;
			end
			SCH_SLOT: begin
				if (slot_zero || slot_free) state_d = SCH_SCAN;
			end
			SCH_DONE: begin
				if (!hold) state_d = SCH_IDLE;
			end
			default: state_d = SCH_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rd_en     = (state_q == SCH_SCAN) && (cnt_q < ctl.n);
		rd_addr   = cnt_q[IdxW-1:0];
		scan_end  = (state_q == SCH_SCAN) && (cnt_q == ctl.n) && !vld_s1;
		slot_zero = (slot_q == '0);
		slot_free = !taken_q[slot_m1[IdxW-1:0]];
		res.done  = (state_q == SCH_DONE) && !hold;
		res.count = count_q;
		res.sum   = sum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SCH_IDLE;
			cnt_q      <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			have_q     <= 1'b0;
			best_idx_q <= '0;
			best_p_q   <= '0;
			best_d_q   <= '0;
			slot_q     <= '0;
			picked_q   <= '0;
			taken_q    <= '0;
			count_q    <= '0;
			sum_q      <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			idx_s1  <= cnt_q[IdxW-1:0];
			if (rd_en) cnt_q <= cnt_q + 1'b1;
			// running maximum over unpicked jobs
			if (vld_s1 && !picked_q[idx_s1] && (!have_q || rd_p > best_p_q)) begin
				have_q     <= 1'b1;
				best_idx_q <= idx_s1;
				best_p_q   <= rd_p;
				best_d_q   <= rd_d;
			end
			unique case (state_q)
				SCH_IDLE: begin
					if (ctl.start) begin
						cnt_q    <= '0;
						have_q   <= 1'b0;
						picked_q <= '0;
						taken_q  <= '0;
						count_q  <= '0;
						sum_q    <= '0;
					end
				end
				SCH_SCAN: begin
					if (scan_end && have_q) begin
						picked_q[best_idx_q] <= 1'b1;
						slot_q               <= best_d_q;
					end
				end
				SCH_SLOT: begin
					if (slot_zero) begin
						cnt_q  <= '0;
						have_q <= 1'b0;
					end else if (slot_free) begin
						taken_q[slot_m1[IdxW-1:0]] <= 1'b1;
						count_q <= count_q + 1'b1;
						sum_q   <= sum_q + SumW'(best_p_q);
						cnt_q   <= '0;
						have_q  <= 1'b0;
					end else begin
						slot_q <= slot_m1;
					end
				end
				SCH_DONE: ;
				default: ;
			endcase
		end
	end
endmodule

// ----- rtl/job_deadline_scheduler.sv -----
// Greedy job sequencer: requests carry one job each (deadline, profit) and are taken one per
// cycle into a 64-entry job memory until the request marked last. The block then stalls its
// input while one shared compare unit scans the stored jobs for the highest remaining profit
// and a slot pointer walks down from that job's deadline to the latest free slot, for up to
// n + 1 rounds for n jobs. One result request (job count, total profit, overflow) follows;
// it waits in an output register while the next set loads. Jobs beyond 64 in a set are
// dropped and flagged.
`include "job_deadline_scheduler_defines.svh"

module job_deadline_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  deadline,
	input  logic [15:0] profit,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  job_count,
	output logic [21:0] total_profit,
	output logic        overflow
);
	import jds_pkg::*;

	logic              busy_q;
	logic              start_q;
	logic [CountW-1:0] n_q;
	logic              ovf_q;
	logic              out_valid_q;
	logic [6:0]        count_q;
	logic [21:0]       sum_q;
	logic              ovf_out_q;

	logic              accept;
	logic              we;
	logic [CountW-1:0] dl;
	logic [EntryW-1:0] rd_data;
	logic [IdxW-1:0]   rd_addr;
	sched_ctl_t        ctl;
	sched_res_t        res;

	assign in_stall = busy_q;
	assign accept   = in_valid && !in_stall;
	assign we       = accept && (n_q < CountW'(MaxJobs));

	always_comb begin
		if (int'(deadline) > MaxJobs) dl = CountW'(MaxJobs);
		else dl = CountW'(deadline);
	end

	assign ctl.start = start_q;
	assign ctl.n     = n_q;

	jds_ram #(.Width(EntryW), .Depth(MaxJobs)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (n_q[IdxW-1:0]),
		.wdata ({profit, dl}),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	jds_sched u_sched (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.hold    (out_valid_q && out_stall),
		.rd_data (rd_data),
		.rd_addr (rd_addr),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			n_q         <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= accept && last;
			if (accept) begin
				if (we) n_q <= n_q + 1'b1;
				else ovf_q <= 1'b1;
				if (last) busy_q <= 1'b1;
			end
			if (res.done) begin
				n_q         <= '0;
				ovf_q       <= 1'b0;
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			count_q   <= 7'(res.count);
			sum_q     <= res.sum;
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign job_count    = count_q;
	assign total_profit = sum_q;
	assign overflow     = ovf_out_q;

	`JDS_ASSERT(a_done_when_busy, res.done |-> busy_q, "result without a loaded set")
	`JDS_ASSERT(a_start_busy, start_q |-> busy_q, "schedule started while input open")
	`JDS_NEVER(a_count_range, n_q > CountW'(MaxJobs), "job count beyond store depth")
endmodule
